### rtl/core/tms_pkg.sv
package tms_pkg;

    localparam int unsigned VIEW_TILES_WIDE_DEF = 20;
    localparam int unsigned VIEW_TILES_HIGH_DEF = 18;

    localparam int unsigned TILE_SHIFT = 3;  // 8 pixels per tile

    localparam logic [7:0] MAP_WIDTH_RESET  = 8'd20;
    localparam logic [7:0] MAP_HEIGHT_RESET = 8'd18;

    // configuration register indexes
    localparam logic [7:0] CFG_MAP_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_MAP_HEIGHT = 8'd1;

    // result item kinds
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_ROW   = 2'd1;
    localparam logic [1:0] KIND_COL   = 2'd2;

    // slots of one frame's packet, in output order
    localparam int unsigned SLOT_ROW   = 0;
    localparam int unsigned SLOT_COL   = 1;
    localparam int unsigned SLOT_FRAME = 2;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  load_tile_x;
        logic [7:0]  load_tile_y;
        logic [4:0]  load_width;
        logic [4:0]  load_height;
        logic [10:0] scroll_x;
        logic [10:0] scroll_y;
        logic        last_item;
    } item_t;

    typedef struct packed {
        logic [2:0]       valid;
        item_t [2:0]      items;
    } packet_t;

    // tiles left from start to the map edge, capped, cut to the 5-bit field
    function automatic logic [4:0] span(logic [7:0] map_tiles, logic [7:0] start,
                                        logic [5:0] cap);
        logic [7:0] left;
        logic [7:0] res;
        left = (start < map_tiles) ? (map_tiles - start) : 8'd0;
        res  = (left < {2'b00, cap}) ? left : {2'b00, cap};
        return res[4:0];
    endfunction

endpackage

### rtl/core/tile_map_scroll_streamer_unit.sv
// channel   | direction | word                                  | accepted when
// s_axis    | in        | tdata[3:0] up, down, left, right      | s_axis_tvalid & s_axis_tready
// m_axis    | out       | tdata load/scroll, tuser kind, tlast  | m_axis_tvalid & m_axis_tready
// cfg       | in        | cfg_index, cfg_data                   | cfg_valid & cfg_ready
//
// A frame word turns into one to three result words, sent one per cycle
// from a packet register while m_axis_tready is high.
// A new frame word is taken in the cycle its predecessor's last word leaves.
// Reset loads the map size registers with 20 x 18 and homes the camera.
// cfg_ready is always high; write only while no frame is in flight.
module tile_map_scroll_streamer_unit #(
    parameter int unsigned VIEW_TILES_WIDE = tms_pkg::VIEW_TILES_WIDE_DEF,
    parameter int unsigned VIEW_TILES_HIGH = tms_pkg::VIEW_TILES_HIGH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // press_up, press_down, press_left, press_right, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // load_tile_x, load_tile_y, load_width, load_height, scroll_x, scroll_y
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // item_kind
    output logic        m_axis_tlast,   // last_item
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    tms_pkg::packet_t packet;
    tms_pkg::item_t   item;
    logic             take;
    logic             space;

    assign s_axis_tready = space;
    assign take          = s_axis_tvalid && space;
    assign cfg_ready     = 1'b1;

    tms_step #(
        .VIEW_TILES_WIDE(VIEW_TILES_WIDE),
        .VIEW_TILES_HIGH(VIEW_TILES_HIGH)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .press    (s_axis_tdata[3:0]),
        .cfg_we   (cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .packet   (packet)
    );

    tms_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .packet   (packet),
        .space    (space),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_item (item)
    );

    assign m_axis_tdata = {item.scroll_y, item.scroll_x, item.load_height, item.load_width,
                           item.load_tile_y, item.load_tile_x};
    assign m_axis_tuser = item.item_kind;
    assign m_axis_tlast = item.last_item;

endmodule

### rtl/core/tms_step.sv
module tms_step #(
    parameter int unsigned VIEW_TILES_WIDE = tms_pkg::VIEW_TILES_WIDE_DEF,
    parameter int unsigned VIEW_TILES_HIGH = tms_pkg::VIEW_TILES_HIGH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [3:0]       press,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    output tms_pkg::packet_t packet
);

    localparam logic [7:0] VW8     = 8'(VIEW_TILES_WIDE);
    localparam logic [7:0] VH8     = 8'(VIEW_TILES_HIGH);
    localparam logic [8:0] VW9     = 9'(VIEW_TILES_WIDE);
    localparam logic [8:0] VH9     = 9'(VIEW_TILES_HIGH);
    localparam logic [5:0] CAP_W   = 6'(VIEW_TILES_WIDE + 1);
    localparam logic [5:0] CAP_H   = 6'(VIEW_TILES_HIGH + 1);

    logic [7:0]  map_w_reg, map_h_reg;
    logic [10:0] cam_x_reg, cam_y_reg, prev_cam_x_reg, prev_cam_y_reg;
    logic [7:0]  tile_col_reg, prev_col_reg, prev_row_reg;

    logic        up, down, left, right;
    logic [10:0] lim_x, lim_y;
    logic [10:0] cam_x_next, cam_y_next;
    logic        move_x, move_y, moved;
    logic [7:0]  row_new, col_new;
    logic        row_chg, col_chg, row_emit, col_emit;
    logic        row_back, col_back;

    assign up    = press[0];
    assign down  = press[1];
    assign left  = press[2];
    assign right = press[3];

    assign lim_x = (map_w_reg > VW8) ? {map_w_reg - VW8, 3'b000} : 11'd0;
    assign lim_y = (map_h_reg > VH8) ? {map_h_reg - VH8, 3'b000} : 11'd0;

    always_comb
    begin
        cam_y_next = cam_y_reg;
        move_y     = 1'b0;
        if (up)
        begin
            if (cam_y_reg != 11'd0)
            begin
                cam_y_next = cam_y_reg - 11'd1;
                move_y     = 1'b1;
            end
        end
        else if (down)
        begin
            if (cam_y_reg < lim_y)
            begin
                cam_y_next = cam_y_reg + 11'd1;
                move_y     = 1'b1;
            end
        end
        cam_x_next = cam_x_reg;
        move_x     = 1'b0;
        if (left)
        begin
            if (cam_x_reg != 11'd0)
            begin
                cam_x_next = cam_x_reg - 11'd1;
                move_x     = 1'b1;
            end
        end
        else if (right)
        begin
            if (cam_x_reg < lim_x)
            begin
                cam_x_next = cam_x_reg + 11'd1;
                move_x     = 1'b1;
            end
        end
    end

    assign moved   = move_x | move_y;
    assign row_new = cam_y_next[10:tms_pkg::TILE_SHIFT];
    assign col_new = cam_x_next[10:tms_pkg::TILE_SHIFT];
    assign row_chg = moved && (row_new != prev_row_reg);
    assign col_chg = moved && (col_new != prev_col_reg);
    assign row_back = cam_y_next < prev_cam_y_reg;
    assign col_back = cam_x_next < prev_cam_x_reg;
    assign row_emit = row_chg && (row_back || ({1'b0, map_h_reg} > ({1'b0, row_new} + VH9)));
    assign col_emit = col_chg && (col_back || ({1'b0, map_w_reg} > ({1'b0, col_new} + VW9)));

    always_comb
    begin
        packet = '0;
        packet.valid[tms_pkg::SLOT_ROW]   = row_emit;
        packet.valid[tms_pkg::SLOT_COL]   = col_emit;
        packet.valid[tms_pkg::SLOT_FRAME] = 1'b1;

        // row load spans from the column held before this frame
        packet.items[tms_pkg::SLOT_ROW].item_kind   = tms_pkg::KIND_ROW;
        packet.items[tms_pkg::SLOT_ROW].load_tile_x = tile_col_reg;
        packet.items[tms_pkg::SLOT_ROW].load_tile_y = row_back ? row_new : row_new + VH8;
        packet.items[tms_pkg::SLOT_ROW].load_width  =
            tms_pkg::span(map_w_reg, tile_col_reg, CAP_W);
        packet.items[tms_pkg::SLOT_ROW].load_height = 5'd1;
        packet.items[tms_pkg::SLOT_ROW].scroll_x    = cam_x_next;
        packet.items[tms_pkg::SLOT_ROW].scroll_y    = cam_y_next;

        packet.items[tms_pkg::SLOT_COL].item_kind   = tms_pkg::KIND_COL;
        packet.items[tms_pkg::SLOT_COL].load_tile_x = col_back ? col_new : col_new + VW8;
        packet.items[tms_pkg::SLOT_COL].load_tile_y = row_new;
        packet.items[tms_pkg::SLOT_COL].load_width  = 5'd1;
        packet.items[tms_pkg::SLOT_COL].load_height =
            tms_pkg::span(map_h_reg, row_new, CAP_H);
        packet.items[tms_pkg::SLOT_COL].scroll_x    = cam_x_next;
        packet.items[tms_pkg::SLOT_COL].scroll_y    = cam_y_next;

        packet.items[tms_pkg::SLOT_FRAME].item_kind = tms_pkg::KIND_FRAME;
        packet.items[tms_pkg::SLOT_FRAME].scroll_x  = cam_x_next;
        packet.items[tms_pkg::SLOT_FRAME].scroll_y  = cam_y_next;
        packet.items[tms_pkg::SLOT_FRAME].last_item = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg      <= tms_pkg::MAP_WIDTH_RESET;
            map_h_reg      <= tms_pkg::MAP_HEIGHT_RESET;
            cam_x_reg      <= '0;
            cam_y_reg      <= '0;
            prev_cam_x_reg <= '0;
            prev_cam_y_reg <= '0;
            tile_col_reg   <= '0;
            prev_col_reg   <= 8'hFF;
            prev_row_reg   <= 8'hFF;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tms_pkg::CFG_MAP_WIDTH:  map_w_reg <= cfg_data;
                    tms_pkg::CFG_MAP_HEIGHT: map_h_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (take)
            begin
                cam_x_reg <= cam_x_next;
                cam_y_reg <= cam_y_next;
                if (moved)
                begin
                    tile_col_reg   <= col_new;
                    prev_cam_x_reg <= cam_x_next;
                    prev_cam_y_reg <= cam_y_next;
                end
                if (row_chg)
                    prev_row_reg <= row_new;
                if (col_chg)
                    prev_col_reg <= col_new;
            end
        end
    end

endmodule

### rtl/core/tms_out.sv
module tms_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  tms_pkg::packet_t packet,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output tms_pkg::item_t   out_item
);

    logic [2:0]            valid_reg;
    tms_pkg::item_t [2:0]  items_reg;
    logic [2:0]            cur;
    logic [2:0]            rest;
    logic                  fire;

    // lowest pending slot goes first
    assign cur       = valid_reg & (~valid_reg + 3'd1);
    assign rest      = valid_reg & ~cur;
    assign out_valid = |valid_reg;
    assign fire      = out_valid && out_ready;
    assign space     = !out_valid || (fire && (rest == 3'b000));

    always_comb
    begin
        case (cur)
            3'b001:  out_item = items_reg[tms_pkg::SLOT_ROW];
            3'b010:  out_item = items_reg[tms_pkg::SLOT_COL];
            default: out_item = items_reg[tms_pkg::SLOT_FRAME];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (load)
            valid_reg <= packet.valid;
        else if (fire)
            valid_reg <= rest;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            items_reg <= packet.items;
    end

endmodule

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VIEW_W     = tms_pkg::VIEW_TILES_WIDE_DEF;
    localparam int unsigned VIEW_H     = tms_pkg::VIEW_TILES_HIGH_DEF;
    localparam int unsigned IDLE_LIMIT = 400;
    localparam int unsigned RUN_ITEMS  = 30;

    // bits of the press word, lowest first
    localparam logic [3:0] PRESS_UP    = 4'b0001;
    localparam logic [3:0] PRESS_DOWN  = 4'b0010;
    localparam logic [3:0] PRESS_LEFT  = 4'b0100;
    localparam logic [3:0] PRESS_RIGHT = 4'b1000;

    typedef struct {
        logic [3:0]  press;
        int unsigned gap;
    } press_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // camera predictor state
    logic [7:0]  map_w;
    logic [7:0]  map_h;
    logic [10:0] cam_x;
    logic [10:0] cam_y;
    logic [10:0] moved_cam_x;
    logic [10:0] moved_cam_y;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [7:0]  seen_col;
    logic [7:0]  seen_row;

    press_word_t     press_queue[$];
    tms_pkg::item_t  due_words[$];
    int unsigned frames_waiting = 0;
    int unsigned gap_max = 14;
    int unsigned stall_max = 14;
    int unsigned mismatches = 0;
    int unsigned words_checked = 0;
    int unsigned gap_cnt = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;

    tile_map_scroll_streamer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [10:0] cam_limit(logic [7:0] tiles, int unsigned view);
        if (tiles > view)
            return 11'((tiles - view) * 8);
        return '0;
    endfunction

    function automatic logic [4:0] edge_span(logic [7:0] tiles, logic [7:0] start,
                                             int unsigned cap);
        int unsigned remain;
        remain = (start < tiles) ? (tiles - start) : 0;
        if (remain > cap)
            remain = cap;
        return 5'(remain);
    endfunction

    function automatic void post_word(logic [1:0] kind, logic [7:0] tx, logic [7:0] ty,
                                      logic [4:0] w, logic [4:0] h, logic last);
        tms_pkg::item_t it;
        it.item_kind   = kind;
        it.load_tile_x = tx;
        it.load_tile_y = ty;
        it.load_width  = w;
        it.load_height = h;
        it.scroll_x    = cam_x;
        it.scroll_y    = cam_y;
        it.last_item   = last;
        due_words.push_back(it);
    endfunction

    function automatic void reset_camera();
        map_w       = tms_pkg::MAP_WIDTH_RESET;
        map_h       = tms_pkg::MAP_HEIGHT_RESET;
        cam_x       = '0;
        cam_y       = '0;
        moved_cam_x = '0;
        moved_cam_y = '0;
        col         = '0;
        row         = '0;
        seen_col    = 8'd255;
        seen_row    = 8'd255;
    endfunction

    // move the camera one frame and queue the edge loads it causes
    function automatic void advance_camera(logic [3:0] press);
        logic       moved;
        logic [4:0] w;
        logic [4:0] h;
        moved = 1'b0;
        if ((press & PRESS_UP) != 0)
        begin
            if (cam_y != 0)
            begin
                cam_y--;
                moved = 1'b1;
            end
        end
        else if ((press & PRESS_DOWN) != 0)
        begin
            if (cam_y < cam_limit(map_h, VIEW_H))
            begin
                cam_y++;
                moved = 1'b1;
            end
        end
        if ((press & PRESS_LEFT) != 0)
        begin
            if (cam_x != 0)
            begin
                cam_x--;
                moved = 1'b1;
            end
        end
        else if ((press & PRESS_RIGHT) != 0)
        begin
            if (cam_x < cam_limit(map_w, VIEW_W))
            begin
                cam_x++;
                moved = 1'b1;
            end
        end

        if (moved)
        begin
            // row check first, still on the old tile column
            row = cam_y[10:3];
            if (row != seen_row)
            begin
                w = edge_span(map_w, col, VIEW_W + 1);
                if (cam_y < moved_cam_y)
                    post_word(tms_pkg::KIND_ROW, col, row, w, 5'd1, 1'b0);
                else if (int'(map_h) > int'(row) + int'(VIEW_H))
                    post_word(tms_pkg::KIND_ROW, col, 8'(row + VIEW_H), w, 5'd1, 1'b0);
                seen_row = row;
            end
            col = cam_x[10:3];
            if (col != seen_col)
            begin
                h = edge_span(map_h, row, VIEW_H + 1);
                if (cam_x < moved_cam_x)
                    post_word(tms_pkg::KIND_COL, col, row, 5'd1, h, 1'b0);
                else if (int'(map_w) > int'(col) + int'(VIEW_W))
                    post_word(tms_pkg::KIND_COL, 8'(col + VIEW_W), row, 5'd1, h, 1'b0);
                seen_col = col;
            end
            moved_cam_x = cam_x;
            moved_cam_y = cam_y;
        end
        post_word(tms_pkg::KIND_FRAME, '0, '0, '0, '0, 1'b1);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(string name, logic [10:0] got, logic [10:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s got %0d, expected %0d",
                                      words_checked, name, got, want));
    endtask

    task automatic check_word();
        tms_pkg::item_t want;
        if (due_words.size() == 0)
            report_mismatch($sformatf("word of kind %0d with no frame pending", m_axis_tuser));
        else
        begin
            want = due_words.pop_front();
            check_field("item_kind",   11'(m_axis_tuser),         11'(want.item_kind));
            check_field("load_tile_x", 11'(m_axis_tdata[7:0]),    11'(want.load_tile_x));
            check_field("load_tile_y", 11'(m_axis_tdata[15:8]),   11'(want.load_tile_y));
            check_field("load_width",  11'(m_axis_tdata[20:16]),  11'(want.load_width));
            check_field("load_height", 11'(m_axis_tdata[25:21]),  11'(want.load_height));
            check_field("scroll_x",    m_axis_tdata[36:26],       want.scroll_x);
            check_field("scroll_y",    m_axis_tdata[47:37],       want.scroll_y);
            check_field("last_item",   11'(m_axis_tlast),         11'(want.last_item));
        end
        words_checked++;
    endtask

    // frame word driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_cnt = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_camera(s_axis_tdata[3:0]);
                frames_waiting--;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (press_queue.size() != 0 && gap_cnt >= press_queue[0].gap)
                begin
                    s_axis_tdata  <= {4'b0000, press_queue[0].press};
                    s_axis_tvalid <= 1'b1;
                    void'(press_queue.pop_front());
                    gap_cnt = 0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    if (press_queue.size() != 0)
                        gap_cnt++;
                end
            end
        end
    end

    // result word monitor, may stall after each word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_word();
                if (stall_max == 0 || $urandom_range(0, 3) == 0)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, stall_max);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // end the run when no word moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[tile_map_scroll_streamer_unit] ERROR");
            $finish;
        end
    end

    task automatic queue_press(logic [3:0] press);
        press_word_t pw;
        pw.press = press;
        if (gap_max == 0 || $urandom_range(0, 3) == 0)
            pw.gap = 0;
        else
            pw.gap = $urandom_range(0, gap_max);
        press_queue.push_back(pw);
        frames_waiting++;
    endtask

    function automatic logic [3:0] pick_axis(logic [3:0] fwd, logic [3:0] back,
                                             int unsigned fwd_pct);
        if ($urandom_range(0, 99) < fwd_pct)
            return fwd;
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return back;
            default: return back | fwd;
        endcase
    endfunction

    // held-direction runs with random content, some runs of pure noise
    task automatic queue_runs(int unsigned count, int unsigned fwd_pct);
        int unsigned made;
        int unsigned len;
        int unsigned i;
        logic [3:0]  heading;
        bit          noisy;
        made = 0;
        while (made < count)
        begin
            len     = $urandom_range(1, 12);
            noisy   = ($urandom_range(0, 99) < 15);
            heading = pick_axis(PRESS_DOWN, PRESS_UP, fwd_pct) |
                      pick_axis(PRESS_RIGHT, PRESS_LEFT, fwd_pct);
            for (i = 0; i < len && made < count; i++)
            begin
                queue_press(noisy ? 4'($urandom) : heading);
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (frames_waiting != 0 || due_words.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == tms_pkg::CFG_MAP_WIDTH)
            map_w = val;
        else if (idx == tms_pkg::CFG_MAP_HEIGHT)
            map_h = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(logic [7:0] w, logic [7:0] h, int unsigned fwd_pct, bit quiet);
        write_reg(tms_pkg::CFG_MAP_WIDTH, w);
        write_reg(tms_pkg::CFG_MAP_HEIGHT, h);
        @(negedge clk);
        gap_max   = quiet ? 0 : 14;
        stall_max = quiet ? 0 : 14;
        queue_runs(RUN_ITEMS, fwd_pct);
        wait_idle();
    endtask

    initial
    begin
        int unsigned p;
        reset_camera();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every press combination on a map the size of the view: nothing moves
        for (p = 0; p < 16; p++)
            queue_press(4'(p));
        wait_idle();

        // first move leaves the reset tile, the eighth crosses a tile edge
        write_reg(tms_pkg::CFG_MAP_WIDTH, 8'd24);
        write_reg(tms_pkg::CFG_MAP_HEIGHT, 8'd22);
        @(negedge clk);
        repeat (9) queue_press(PRESS_DOWN | PRESS_RIGHT);
        wait_idle();

        run_phase(8'd24,  8'd22,  60, 1'b0);
        run_phase(8'd255, 8'd255, 70, 1'b0);
        run_phase(8'd21,  8'd19,  50, 1'b1);
        run_phase(8'd40,  8'd30,  85, 1'b0);
        // shrink under the camera: it sits past the limit and past the map edge
        run_phase(8'd2,   8'd1,   30, 1'b0);
        run_phase(8'd0,   8'd0,   40, 1'b1);
        run_phase(8'd20,  8'd18,  50, 1'b0);
        run_phase(8'd255, 8'd18,  60, 1'b0);
        run_phase(8'd18,  8'd255, 60, 1'b1);
        run_phase(8'd30,  8'd40,  55, 1'b0);
        run_phase(8'd255, 8'd1,   50, 1'b0);

        if (due_words.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", due_words.size()));
        if (mismatches == 0)
            $display("[tile_map_scroll_streamer_unit] OK");
        else
            $display("[tile_map_scroll_streamer_unit] ERROR");
        $finish;
    end

endmodule
